// ===== src/lrs_pkg.sv =====
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared widths, codes and reset values for the link retry supervisor.
// ----------------------------------------------------------------------------
`default_nettype none

package lrs_pkg;

    localparam int unsigned TimeW   = 32;
    localparam int unsigned CountW  = 32;
    localparam int unsigned StateW  = 2;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 32;

    // tdata widths, padded to whole bytes
    localparam int unsigned InDataW  = 40;
    localparam int unsigned OutDataW = 40;

    // link states
    localparam logic [StateW-1:0] ST_IDLE       = 2'd0;
    localparam logic [StateW-1:0] ST_CONNECTING = 2'd1;
    localparam logic [StateW-1:0] ST_CONNECTED  = 2'd2;
    localparam logic [StateW-1:0] ST_RESTART    = 2'd3;

    // item kinds
    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_ATTEMPT_TIMEOUT = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_TIMEOUT_LIMIT   = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_RESTART_ENABLE  = 2'd2;

    localparam logic [TimeW-1:0]  ATTEMPT_TIMEOUT_RST = 32'd10000;
    localparam logic [CountW-1:0] TIMEOUT_LIMIT_RST   = 32'd0;
    localparam logic [CountW-1:0] COUNT_MAX           = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [StateW-1:0] link_state;
        logic              begin_attempt;
        logic              restart_request;
        logic [CountW-1:0] timeouts_so_far;
        logic              connected_now;
    } result_t;

endpackage

`default_nettype wire

// ===== src/link_retry_supervisor_core.sv =====
// ----------------------------------------------------------------------------
// link_retry_supervisor_core
// Connect/retry supervisor: tracks link state, attempt timeouts and restarts.
// ----------------------------------------------------------------------------
// Pipeline: a request passes the input register, then the result register; state
//   and count update in the same cycle as the result.
// Throughput: one request per cycle while the result is not stalled; a stalled result holds both stages.
// Reset (aresetn low, synchronous): state idle, count and start time zero,
//   registers at their reset values, both stages empty.
`default_nettype none

module link_retry_supervisor_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input requests
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [39:0] s_tdata,  // [0] name_present, [1] link_up, [33:2] now_ms
    input  wire logic        s_tuser,  // [0] kind
    // results
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [39:0] m_tdata,  // [1:0] link_state, [2] begin_attempt,
                                       // [3] restart_request, [35:4] timeouts_so_far,
                                       // [36] connected_now
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    // configuration registers
    logic [lrs_pkg::TimeW-1:0]  attempt_timeout_reg;
    logic [lrs_pkg::CountW-1:0] timeout_limit_reg;
    logic                       restart_enable_reg;

    // supervisor state
    logic [lrs_pkg::StateW-1:0] state_reg, state_next;
    logic [lrs_pkg::CountW-1:0] count_reg, count_next;
    logic [lrs_pkg::TimeW-1:0]  start_reg, start_next;

    // input stage
    logic                      in_valid_reg;
    logic                      in_kind_reg;
    logic                      in_name_reg;
    logic                      in_up_reg;
    logic [lrs_pkg::TimeW-1:0] in_now_reg;

    // result stage
    logic             out_valid_reg;
    lrs_pkg::result_t out_reg, out_next;

    logic advance;
    logic process;

    logic [lrs_pkg::TimeW-1:0]  elapsed;
    logic                       timed_out;
    logic [lrs_pkg::CountW-1:0] count_inc;
    logic                       at_limit;
    logic                       began;
    logic                       restarted;

    assign advance  = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attempt_timeout_reg <= lrs_pkg::ATTEMPT_TIMEOUT_RST;
            timeout_limit_reg   <= lrs_pkg::TIMEOUT_LIMIT_RST;
            restart_enable_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lrs_pkg::REG_ATTEMPT_TIMEOUT: attempt_timeout_reg <= cfg_wdata;
                lrs_pkg::REG_TIMEOUT_LIMIT:   timeout_limit_reg   <= cfg_wdata;
                lrs_pkg::REG_RESTART_ENABLE:  restart_enable_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg <= s_tuser;
            in_name_reg <= s_tdata[0];
            in_up_reg   <= s_tdata[1];
            in_now_reg  <= s_tdata[33:2];
        end
    end

    // wrapping elapsed time of the current attempt
    assign elapsed   = in_now_reg - start_reg;
    assign timed_out = elapsed >= attempt_timeout_reg;
    assign count_inc = (count_reg == lrs_pkg::COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign at_limit  = (timeout_limit_reg != '0) && (count_inc >= timeout_limit_reg);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        start_next = start_reg;
        began      = 1'b0;
        restarted  = 1'b0;

        if (in_kind_reg == lrs_pkg::KIND_START) begin
            if (!in_name_reg) begin
                state_next = lrs_pkg::ST_IDLE;
            end else begin
                count_next = '0;
                start_next = in_now_reg;
                state_next = lrs_pkg::ST_CONNECTING;
                began      = 1'b1;
            end
        end else if (state_reg == lrs_pkg::ST_CONNECTING ||
                     state_reg == lrs_pkg::ST_CONNECTED) begin
            if (in_up_reg) begin
                state_next = lrs_pkg::ST_CONNECTED;
                count_next = '0;
            end else if (state_reg == lrs_pkg::ST_CONNECTED) begin
                start_next = in_now_reg;
                state_next = lrs_pkg::ST_CONNECTING;
                began      = 1'b1;
            end else if (timed_out) begin
                if (at_limit && restart_enable_reg) begin
                    count_next = count_inc;
                    state_next = lrs_pkg::ST_RESTART;
                    restarted  = 1'b1;
                end else begin
                    count_next = at_limit ? '0 : count_inc;
                    start_next = in_now_reg;
                    state_next = lrs_pkg::ST_CONNECTING;
                    began      = 1'b1;
                end
            end
        end

        out_next.link_state      = state_next;
        out_next.begin_attempt   = began;
        out_next.restart_request = restarted;
        out_next.timeouts_so_far = count_next;
        out_next.connected_now   = (state_next == lrs_pkg::ST_CONNECTED) && in_up_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lrs_pkg::ST_IDLE;
            count_reg <= '0;
            start_reg <= '0;
        end else if (process) begin
            state_reg <= state_next;
            count_reg <= count_next;
            start_reg <= start_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (process) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.connected_now, out_reg.timeouts_so_far,
                       out_reg.restart_request, out_reg.begin_attempt, out_reg.link_state};

    // a fresh attempt always records its start time and leaves us connecting
    a_begin_records_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (process && began) |=>
            (state_reg == lrs_pkg::ST_CONNECTING) && (start_reg == $past(in_now_reg)))
        else $error("attempt start not recorded");

    // restart only when enabled and the limit has been reached
    a_restart_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (process && restarted) |->
            restart_enable_reg && (timeout_limit_reg != '0) &&
            (count_next >= timeout_limit_reg))
        else $error("restart requested below limit");

    // result state matches the live state after each processed request
    a_result_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        process |=> (out_reg.link_state == state_reg))
        else $error("result state differs from live state");

    // idle and restart states are left only by a start request
    a_hold_without_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (process && in_kind_reg == lrs_pkg::KIND_UPDATE &&
         (state_reg == lrs_pkg::ST_IDLE || state_reg == lrs_pkg::ST_RESTART)) |=>
            $stable(state_reg) && $stable(count_reg) && $stable(start_reg))
        else $error("update changed an idle or restart state");

    // a stalled result holds the input stage
    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while result stalled");

endmodule

`default_nettype wire
